/* rtl/apic_cdt_pkg.sv */
// shared constants and types for the countdown timer block
`default_nettype none

package apic_cdt_pkg;

  // action codes carried in the input word's tuser
  typedef logic [1:0] action_t;
  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_WRITE = 2'd2;

  // register indexes, byte offset divided by 16
  typedef logic [5:0] reg_idx_t;
  localparam reg_idx_t IDX_ID        = 6'h02;
  localparam reg_idx_t IDX_LVT_TIMER = 6'h32;
  localparam reg_idx_t IDX_INITIAL   = 6'h38;
  localparam reg_idx_t IDX_CURRENT   = 6'h39;
  localparam reg_idx_t IDX_DIVIDE    = 6'h3e;

  // lvt timer modes
  typedef logic [1:0] timer_mode_t;
  localparam timer_mode_t MODE_ONE_SHOT = 2'd0;
  localparam timer_mode_t MODE_PERIODIC = 2'd1;
  localparam timer_mode_t MODE_DEADLINE = 2'd2;

  // divide configuration bits that are kept
  localparam logic [3:0] DIVIDE_KEEP_MASK = 4'hb;
  // select code that means divide by one
  localparam logic [2:0] DIV_SEL_BY_ONE = 3'd7;

  // word widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // result word contents
  typedef struct packed {
    logic [6:0]  pad;
    logic [7:0]  interrupt_vector;
    logic        interrupt_raised;
    logic [31:0] read_data;
  } result_t;

endpackage

`default_nettype wire

/* rtl/apic_style_countdown_timer_top.sv */
// local-interrupt-controller style countdown timer, register file and result stage
`default_nettype none

// usage
//  in channel: one word per bus clock tick, register read or register write.
//    in_tuser carries the action, in_tdata the register index and write data.
//  out channel: exactly one result word per input word, in order: read data,
//    interrupt flag and vector.
//  cfg port: cfg_wen writes the unit id returned in the id register, taken at
//    once; write it only while the block is idle, the block does not enforce it.
//  latency: the result of a word shows on out_* the cycle after it is taken.
//  throughput: one word per cycle while out_tready stays high; state is updated
//    by a single combinational pass at the accepting edge, and the result
//    register is refilled in the same cycle it is drained.
//  stall: while out_tready is low a waiting result holds and in_tready drops,
//    so nothing is lost; in_tready returns as soon as the result is taken.
//  reset: synchronous, active low; the timer comes up masked, one-shot,
//    divide by two, with all counts zero and no result pending.
//  the prescaler divides ticks by 1 to 128; the current count drops at each
//    prescaler wrap and raises the lvt vector at zero unless masked.
module apic_style_countdown_timer_top
  import apic_cdt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [5:0] register_index, [37:6] write_data, [39:38] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  wire logic [1:0]             in_tuser,
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [31:0] read_data, [32] interrupt_raised, [40:33] interrupt_vector, [47:41] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // configuration
  input  wire logic                   cfg_wen,
  input  wire logic [7:0]             cfg_wdata
);

  // timer state
  logic [7:0]  unit_id_r;
  logic [7:0]  vector_r,    vector_nxt;
  logic        masked_r,    masked_nxt;
  timer_mode_t mode_r,      mode_nxt;
  logic [3:0]  divide_r,    divide_nxt;
  logic [31:0] initial_r,   initial_nxt;
  logic [31:0] current_r,   current_nxt;
  logic [6:0]  prescale_r,  prescale_nxt;

  // result stage
  logic        out_valid_r, out_valid_nxt;
  result_t     result_r,    result_nxt;

  // input word fields
  action_t     action;
  reg_idx_t    reg_idx;
  logic [31:0] wdata;
  logic        in_accept;

  // tick datapath
  logic [2:0]  div_sel;
  logic [8:0]  divisor;
  logic [8:0]  prescale_inc;
  logic        prescale_wrap;
  logic        stopped;
  logic [31:0] current_dec;

  assign action  = in_tuser;
  assign reg_idx = in_tdata[5:0];
  assign wdata   = in_tdata[37:6];

  // take a word whenever the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  // divisor from code bits 3,1,0: 2 << sel, or 1 for the all-ones code
  assign div_sel      = {divide_r[3], divide_r[1:0]};
  assign divisor      = (div_sel == DIV_SEL_BY_ONE) ? 9'd1 : (9'd2 << div_sel);
  assign prescale_inc = {2'b00, prescale_r} + 9'd1;
  assign prescale_wrap = !(prescale_inc < divisor);
  // deadline and reserved modes have mode bit 1 set and count as stopped
  assign stopped      = mode_r[1] || (current_r == 32'd0);
  assign current_dec  = current_r - 32'd1;

  always_comb begin
    vector_nxt    = vector_r;
    masked_nxt    = masked_r;
    mode_nxt      = mode_r;
    divide_nxt    = divide_r;
    initial_nxt   = initial_r;
    current_nxt   = current_r;
    prescale_nxt  = prescale_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      out_valid_nxt = 1'b1;
      result_nxt    = '0;
      case (action)
        ACT_TICK: begin
          if (!stopped) begin
            if (!prescale_wrap) begin
              prescale_nxt = prescale_inc[6:0];
            end else begin
              prescale_nxt = 7'd0;
              current_nxt  = current_dec;
              if (current_dec == 32'd0) begin
                if (mode_r == MODE_PERIODIC) begin
                  current_nxt = initial_r;
                end
                if (!masked_r) begin
                  result_nxt.interrupt_raised = 1'b1;
                  result_nxt.interrupt_vector = vector_r;
                end
              end
            end
          end
        end
        ACT_READ: begin
          case (reg_idx)
            IDX_ID:        result_nxt.read_data = {unit_id_r, 24'd0};
            IDX_LVT_TIMER: result_nxt.read_data = {13'd0, mode_r, masked_r, 8'd0, vector_r};
            IDX_INITIAL:   result_nxt.read_data = initial_r;
            IDX_CURRENT:   result_nxt.read_data = current_r;
            IDX_DIVIDE:    result_nxt.read_data = {28'd0, divide_r};
            default:       result_nxt.read_data = 32'd0;
          endcase
        end
        ACT_WRITE: begin
          case (reg_idx)
            IDX_LVT_TIMER: begin
              vector_nxt = wdata[7:0];
              masked_nxt = wdata[16];
              mode_nxt   = wdata[18:17];
            end
            IDX_INITIAL: begin
              // load and restart; zero stops the timer
              initial_nxt  = wdata;
              current_nxt  = wdata;
              prescale_nxt = 7'd0;
            end
            IDX_DIVIDE: begin
              divide_nxt = wdata[3:0] & DIVIDE_KEEP_MASK;
            end
            default: begin
              // read-only and unknown registers ignore writes
            end
          endcase
        end
        default: begin
          // unused action code, result stays all zero
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r   <= 8'd0;
      vector_r    <= 8'd0;
      masked_r    <= 1'b1;
      mode_r      <= MODE_ONE_SHOT;
      divide_r    <= 4'd0;
      initial_r   <= 32'd0;
      current_r   <= 32'd0;
      prescale_r  <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unit_id_r <= cfg_wdata;
      end
      vector_r    <= vector_nxt;
      masked_r    <= masked_nxt;
      mode_r      <= mode_nxt;
      divide_r    <= divide_nxt;
      initial_r   <= initial_nxt;
      current_r   <= current_nxt;
      prescale_r  <= prescale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

`ifndef ASSERT_OFF
  // a tick on a zero count never raises an interrupt
  a_no_irq_when_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && action == ACT_TICK && current_r == 32'd0)
      |=> (out_tvalid && !out_tdata[32]))
    else $error("interrupt raised from a zero count");

  // an interrupt result never carries read data
  a_irq_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] == 32'd0))
    else $error("interrupt result with read data");

  // an initial count write loads the counter and clears the prescaler
  a_initial_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && action == ACT_WRITE && reg_idx == IDX_INITIAL)
      |=> (current_r == $past(wdata) && prescale_r == 7'd0))
    else $error("initial count write did not load the counter");

  // the mode field only moves on an lvt write
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && action == ACT_WRITE && reg_idx == IDX_LVT_TIMER)
      |=> $stable(mode_r))
    else $error("timer mode changed without an lvt write");
`endif

endmodule

`default_nettype wire

/* tb/apic_cdt_checker.sv */
// result checker for the countdown timer: timer prediction and word-by-word compare
`default_nettype none

module apic_cdt_checker
  import apic_cdt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [1:0]             in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_wen,
  input  wire logic [7:0]             cfg_wdata,
  output int unsigned                 fail_cnt,
  output int unsigned                 pending_cnt,
  output int unsigned                 irq_cnt
);

  // predicted timer state
  logic [7:0]  unit_id;
  logic [7:0]  vec;
  logic        masked;
  timer_mode_t mode;
  logic [3:0]  div_code;
  logic [31:0] init_cnt;
  logic [31:0] cur_cnt;
  logic [6:0]  presc;

  result_t result_q[$];

  function automatic int unsigned tick_divisor(input logic [3:0] code);
    logic [2:0] sel;
    sel = {code[3], code[1:0]};
    if (sel == DIV_SEL_BY_ONE) return 1;
    return 2 << sel;
  endfunction

  // advances the predicted timer by one word and returns its result
  function automatic result_t timer_step(input action_t act, input reg_idx_t idx,
                                         input logic [31:0] d);
    result_t r;
    r = '0;
    case (act)
      ACT_TICK: begin
        if (mode < MODE_DEADLINE && cur_cnt != 0) begin
          if (presc + 1 < tick_divisor(div_code)) begin
            presc = presc + 7'd1;
          end else begin
            presc = '0;
            cur_cnt = cur_cnt - 32'd1;
            if (cur_cnt == 0) begin
              if (mode == MODE_PERIODIC) cur_cnt = init_cnt;
              if (!masked) begin
                r.interrupt_raised = 1'b1;
                r.interrupt_vector = vec;
              end
            end
          end
        end
      end
      ACT_READ: begin
        case (idx)
          IDX_ID:        r.read_data = {unit_id, 24'h0};
          IDX_LVT_TIMER: r.read_data = {13'h0, mode, masked, 8'h0, vec};
          IDX_INITIAL:   r.read_data = init_cnt;
          IDX_CURRENT:   r.read_data = cur_cnt;
          IDX_DIVIDE:    r.read_data = {28'h0, div_code};
          default:       r.read_data = '0;
        endcase
      end
      ACT_WRITE: begin
        case (idx)
          IDX_LVT_TIMER: begin
            vec = d[7:0];
            masked = d[16];
            mode = d[18:17];
          end
          IDX_INITIAL: begin
            init_cnt = d;
            cur_cnt = d;
            presc = '0;
          end
          IDX_DIVIDE: div_code = d[3:0] & DIVIDE_KEEP_MASK;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      unit_id = '0;
      vec = '0;
      masked = 1'b1;
      mode = MODE_ONE_SHOT;
      div_code = '0;
      init_cnt = '0;
      cur_cnt = '0;
      presc = '0;
      result_q.delete();
      fail_cnt = 0;
      irq_cnt = 0;
    end else begin
      if (cfg_wen) unit_id = cfg_wdata;
      // results come after their word is taken, so pop before push
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (result_q.size() == 0) begin
          $error("result word %h with nothing expected", out_tdata);
          fail_cnt++;
        end else begin
          want = result_q.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("interrupt_raised", 32'(want.interrupt_raised),
                      32'(got.interrupt_raised));
          check_field("interrupt_vector", 32'(want.interrupt_vector),
                      32'(got.interrupt_vector));
          check_field("pad", 32'(want.pad), 32'(got.pad));
          if (got.interrupt_raised) irq_cnt++;
        end
      end
      if (in_tvalid && in_tready) begin
        result_q.push_back(timer_step(in_tuser, in_tdata[5:0], in_tdata[37:6]));
      end
    end
    pending_cnt <= result_q.size();
  end

endmodule

`default_nettype wire

/* tb/apic_style_countdown_timer_top_tb.sv */
// stimulus and verdict for the countdown timer block
`default_nettype none

module apic_style_countdown_timer_top_tb;
  import apic_cdt_pkg::*;

  // cycles with no word moving on either side before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 240;
  // long receiver hold-off, far longer than the block can buffer
  localparam int unsigned HOLD_CYCLES = 300;

  // offsets with no register behind them, and the unused action code
  localparam reg_idx_t IDX_UNUSED = 6'h00;
  localparam reg_idx_t IDX_TOP    = 6'h3f;
  localparam action_t  ACT_NONE   = 2'd3;

  localparam reg_idx_t KNOWN_REGS [5] = '{IDX_ID, IDX_LVT_TIMER, IDX_INITIAL,
                                          IDX_CURRENT, IDX_DIVIDE};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = ACT_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wen = 1'b0;
  logic [7:0]             cfg_wdata = '0;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned irq_cnt;

  // idling chance in percent for both sides, zero during the calm phase
  int unsigned idle_pct = 18;
  // set by the stimulus to ask the receiver for one long hold-off
  bit          hold_req = 1'b0;
  int unsigned words_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  apic_style_countdown_timer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  apic_cdt_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .irq_cnt     (irq_cnt)
  );

  // offers one word and returns at the edge that takes it; tvalid stays high
  // so back-to-back words never lower and raise it in one step
  task automatic send_word(input action_t act, input reg_idx_t idx, input logic [31:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {2'b00, d, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // stops offering and waits until every expected result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    // result stage is one deep, a few spare cycles cover it
    repeat (4) @(posedge clk);
  endtask

  // unit id write, only called while the block is idle
  task automatic set_unit_id(input logic [7:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // random word, mostly well-formed timer programming and ticks so the
  // count keeps reaching zero; the rest is stray offsets and noise
  task automatic send_random();
    int unsigned pick;
    logic [31:0] d;
    reg_idx_t    idx;
    action_t     act;
    pick = $urandom_range(99);
    d = $urandom;
    idx = reg_idx_t'($urandom_range(63));
    if (pick < 55) begin
      act = ACT_TICK;
    end else if (pick < 72) begin
      act = ACT_READ;
      if (pick < 68) idx = KNOWN_REGS[$urandom_range(4)];
    end else if (pick < 96) begin
      act = ACT_WRITE;
      case ($urandom_range(9))
        0, 1, 2: begin
          // lvt: mostly unmasked, mostly one-shot or periodic
          idx = IDX_LVT_TIMER;
          d[16] = ($urandom_range(3) == 0);
          if ($urandom_range(4) != 0) d[18] = 1'b0;
        end
        3, 4, 5, 6: begin
          // short counts, zero now and then to stop the timer
          idx = IDX_INITIAL;
          if ($urandom_range(7) != 0) d = $urandom_range(12);
        end
        7, 8: begin
          // mostly fast divisors: by one, two or four
          idx = IDX_DIVIDE;
          case ($urandom_range(3))
            0: d[3:0] = 4'hb;
            1: d[3:0] = 4'h0;
            2: d[3:0] = 4'h1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end else begin
      act = action_t'($urandom_range(3));
    end
    send_word(act, idx, d);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // watchdog on cycles where nothing moves
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_unit_id(8'hff);

    // reset values and a tick while the count is zero
    send_word(ACT_READ, IDX_ID, '0);
    send_word(ACT_READ, IDX_LVT_TIMER, '0);
    send_word(ACT_TICK, IDX_TOP, 32'hffff_ffff);
    // periodic, unmasked, vector ff, junk in the ignored lvt bits
    send_word(ACT_WRITE, IDX_LVT_TIMER, 32'hfffa_ffff);
    // all ones keeps code b: divide by one
    send_word(ACT_WRITE, IDX_DIVIDE, 32'hffff_ffff);
    send_word(ACT_WRITE, IDX_INITIAL, 32'd2);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    // reaches zero, raises ff and reloads
    send_word(ACT_TICK, IDX_UNUSED, '0);
    send_word(ACT_READ, IDX_CURRENT, '0);
    // divide by two with upper junk, then a maximum count
    send_word(ACT_WRITE, IDX_DIVIDE, 32'hffff_fff0);
    send_word(ACT_WRITE, IDX_INITIAL, 32'hffff_ffff);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    // divide change while running: prescaler already past the new limit
    send_word(ACT_WRITE, IDX_DIVIDE, 32'h0000_000b);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    send_word(ACT_READ, IDX_CURRENT, '0);
    // deadline and reserved modes leave the count alone
    send_word(ACT_WRITE, IDX_LVT_TIMER, 32'h0004_0020);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    send_word(ACT_WRITE, IDX_LVT_TIMER, 32'h0006_0000);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    // masked one-shot reaches zero silently
    send_word(ACT_WRITE, IDX_LVT_TIMER, 32'h0001_0000);
    send_word(ACT_WRITE, IDX_INITIAL, 32'd1);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    // unmasked one-shot fires once and stays at zero
    send_word(ACT_WRITE, IDX_LVT_TIMER, 32'h0000_0040);
    send_word(ACT_WRITE, IDX_INITIAL, 32'd1);
    send_word(ACT_TICK, IDX_UNUSED, '0);
    send_word(ACT_READ, IDX_CURRENT, '0);
    // read-only and unknown offsets, unused action code, stop by zero count
    send_word(ACT_WRITE, IDX_ID, 32'hffff_ffff);
    send_word(ACT_WRITE, IDX_CURRENT, 32'h0000_1234);
    send_word(ACT_READ, IDX_UNUSED, '0);
    send_word(ACT_NONE, IDX_TOP, 32'hffff_ffff);
    send_word(ACT_WRITE, IDX_INITIAL, '0);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_unit_id(8'h00);
        1: set_unit_id(8'h5a);
        4: set_unit_id(8'hff);
        default: set_unit_id(8'($urandom_range(255)));
      endcase
      // phase 2 runs with no idling on either side
      idle_pct = (p == 2) ? 0 : 18;
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (p == 3 && k == 40) hold_req = 1'b1;
        send_random();
      end
      drain();
    end

    $display("run covered %0d words: directed register and timer cases, then %0d random phases",
             words_sent, PHASES);
    $display("unit ids 00, 5a, ff and random, %0d interrupts delivered, one long receiver hold-off",
             irq_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
